@@ rtl/tac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_pkg: shared types and constants of the target approach controller
// Item codes, configuration and state records, and register reset values.
// ----------------------------------------------------------------------------
package tac_pkg;

  // Timing limits, in control ticks
  localparam logic [7:0] TimeoutTicks  = 8'd20;
  localparam logic [7:0] LostTurnTicks = 8'd10;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_DETECT  = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_TRIGGER = 2'd2
  } func_e;

  // Reported control state
  typedef enum logic [1:0] {
    PHASE_INIT    = 2'd0,
    PHASE_WORKING = 2'd1,
    PHASE_DONE    = 2'd2
  } phase_e;

  // Mode chosen by the last trigger
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_DONE = 2'd2
  } mode_e;

  localparam logic [7:0] TrigRun  = 8'd1;
  localparam logic [7:0] TrigDone = 8'd2;

  // Register indexes (byte address / 4)
  localparam logic [2:0] RegStart  = 3'd0;
  localparam logic [2:0] RegStop   = 3'd1;
  localparam logic [2:0] RegGain   = 3'd2;
  localparam logic [2:0] RegWeight = 3'd3;
  localparam logic [2:0] RegFwd    = 3'd4;
  localparam logic [2:0] RegTarget = 3'd5;
  localparam logic [2:0] RegClose  = 3'd6;
  localparam logic [2:0] RegConf   = 3'd7;

  typedef struct packed {
    logic [11:0] turn_start;
    logic [11:0] turn_stop;
    logic [15:0] turn_gain;
    logic [8:0]  weight;
    logic [15:0] fwd_speed;
    logic [11:0] target_col;
    logic [15:0] close_dist;
    logic [7:0]  conf_thresh;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    turn_start:  12'd30,
    turn_stop:   12'd15,
    turn_gain:   16'd66,
    weight:      9'd51,
    fwd_speed:   16'd256,
    target_col:  12'd424,
    close_dist:  16'd2000,
    conf_thresh: 8'd3
  };

  typedef struct packed {
    logic [19:0] fcol;        // Q12.8
    logic [23:0] fdep;        // Q17.7
    logic        primed;
    logic [8:0]  count;
    phase_e      phase;
    logic        turning;
    logic        stop_sent;
    logic        motion;
    logic        close_seen;
    mode_e       mode;
    logic [7:0]  ticks;
  } state_t;

  localparam state_t StateReset = '{
    fcol: '0, fdep: '0, primed: 1'b0, count: '0, phase: PHASE_INIT,
    turning: 1'b0, stop_sent: 1'b0, motion: 1'b0, close_seen: 1'b0,
    mode: MODE_IDLE, ticks: '0
  };

  typedef struct packed {
    func_e       func;
    logic [11:0] pixel_column;
    logic [15:0] depth_mm;
    logic [7:0]  trigger_value;
  } item_t;

  typedef struct packed {
    logic               cmd_valid;
    logic [15:0]        forward_cmd;
    logic signed [15:0] turn_cmd;
    phase_e             control_state;
  } result_t;

endpackage

@@ rtl/target_approach_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// target_approach_controller_core: steering toward a visual target
// Item input stage, single-pass control logic, result register, APB registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser is the item kind (detection, tick, trigger),
//   tdata holds pixel column, depth and trigger value. Every item gives exactly
//   one result item on m_axis: tuser is cmd_valid, tdata holds forward command,
//   turn command and control state.
//   An accepted item is held in the input register; the control logic then
//   updates the state and loads the result register, which offers the result
//   once the receiver has taken the previous one. One item per cycle is
//   sustained with no gaps while the receiver takes every result.
//   When the receiver stalls, the result register holds and the input register
//   fills; s_axis_tready drops while both are occupied and m_axis_tready is low.
//   Reset clears the control state and loads the register defaults; no items
//   are in flight afterwards. Registers are written over APB at 4*index and
//   should only change while no item is in flight.
// ----------------------------------------------------------------------------
module target_approach_controller_core import tac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // pixel_column[11:0], depth_mm[27:12], trigger_value[35:28]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // forward_cmd[15:0], turn_cmd[31:16], control_state[33:32]
  output logic        m_axis_tuser,  // cmd_valid
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   in_item_q;
  logic    in_vld_q;
  result_t out_res_q, step_res;
  logic    out_vld_q;
  logic    out_free;
  logic    advance;
  logic [2:0] reg_idx;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegStart:  cfg_q.turn_start  <= pwdata[11:0];
        RegStop:   cfg_q.turn_stop   <= pwdata[11:0];
        RegGain:   cfg_q.turn_gain   <= pwdata[15:0];
        RegWeight: cfg_q.weight      <= pwdata[8:0];
        RegFwd:    cfg_q.fwd_speed   <= pwdata[15:0];
        RegTarget: cfg_q.target_col  <= pwdata[11:0];
        RegClose:  cfg_q.close_dist  <= pwdata[15:0];
        RegConf:   cfg_q.conf_thresh <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      RegStart:  prdata = {20'd0, cfg_q.turn_start};
      RegStop:   prdata = {20'd0, cfg_q.turn_stop};
      RegGain:   prdata = {16'd0, cfg_q.turn_gain};
      RegWeight: prdata = {23'd0, cfg_q.weight};
      RegFwd:    prdata = {16'd0, cfg_q.fwd_speed};
      RegTarget: prdata = {20'd0, cfg_q.target_col};
      RegClose:  prdata = {16'd0, cfg_q.close_dist};
      RegConf:   prdata = {24'd0, cfg_q.conf_thresh};
      default:   prdata = '0;
    endcase
  end

  // Handshake: the result register frees when taken, the input register
  // frees when its item moves on
  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= StateReset;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.func          <= func_e'(s_axis_tuser);
      in_item_q.pixel_column  <= s_axis_tdata[11:0];
      in_item_q.depth_mm      <= s_axis_tdata[27:12];
      in_item_q.trigger_value <= s_axis_tdata[35:28];
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  tac_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // Result packing
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.cmd_valid;
  assign m_axis_tdata  = {6'd0, out_res_q.control_state, out_res_q.turn_cmd,
                          out_res_q.forward_cmd};

endmodule

@@ rtl/tac_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_step: next-state and result logic for one item
// Filters detections; timeout, turn hysteresis, approach on ticks; mode triggers.
// ----------------------------------------------------------------------------
module tac_step import tac_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [8:0]         w;
  logic [16:0]        dep_clamp;
  logic [23:0]        dep_sample;
  logic signed [20:0] col_diff;
  logic signed [30:0] col_prod;
  logic [31:0]        col_acc;
  logic signed [24:0] dep_diff;
  logic signed [34:0] dep_prod;
  logic [35:0]        dep_acc;
  logic [9:0]         cnt_inc;
  logic [9:0]         cnt_cap;
  logic [7:0]         ticks_inc;
  logic [20:0]        err;
  logic [19:0]        mag;
  logic [36:0]        turn_acc;
  logic [24:0]        turn_r;
  logic [15:0]        turn_sat;
  logic [15:0]        turn_t;

  // Weight limited to 1.0, depth clamp
  always_comb begin
    w = (cfg_i.weight > 9'd256) ? 9'd256 : cfg_i.weight;
    if (item_i.depth_mm < 16'd100) begin
      dep_clamp = {1'b0, cfg_i.close_dist} + 17'd500;
    end else if (item_i.depth_mm > 16'd10000) begin
      dep_clamp = 17'd10000;
    end else begin
      dep_clamp = {1'b0, item_i.depth_mm};
    end
    dep_sample = {dep_clamp, 7'd0};
  end

  // Low-pass: old + ((new - old) * w + 128) >> 8, one multiplier per filter
  always_comb begin
    col_diff = $signed({1'b0, item_i.pixel_column, 8'd0}) - $signed({1'b0, state_i.fcol});
    col_prod = col_diff * $signed({1'b0, w});
    col_acc  = {4'd0, state_i.fcol, 8'd0} + {col_prod[30], col_prod} + 32'd128;
    dep_diff = $signed({1'b0, dep_sample}) - $signed({1'b0, state_i.fdep});
    dep_prod = dep_diff * $signed({1'b0, w});
    dep_acc  = {4'd0, state_i.fdep, 8'd0} + {dep_prod[34], dep_prod} + 36'd128;
  end

  // Confidence count and tick counter increments
  always_comb begin
    cnt_inc   = {1'b0, state_i.count} + 10'd1;
    cnt_cap   = {2'd0, cfg_i.conf_thresh} + 10'd2;
    ticks_inc = (state_i.ticks == 8'hFF) ? state_i.ticks : state_i.ticks + 8'd1;
  end

  // Proportional turn: |err| * gain, rounded, saturated to Q3.12
  always_comb begin
    err      = {1'b0, cfg_i.target_col, 8'd0} - {1'b0, state_i.fcol};
    mag      = err[20] ? 20'(-err) : err[19:0];
    turn_acc = 37'(mag) * 37'(cfg_i.turn_gain) + 37'd2048;
    turn_r   = turn_acc[36:12];
    if (err[20]) begin
      turn_sat = (turn_r > 25'd32768) ? 16'h8000 : 16'(-turn_r);
    end else begin
      turn_sat = (turn_r > 25'd32767) ? 16'h7FFF : turn_r[15:0];
    end
  end

  // Item dispatch
  always_comb begin
    state_o  = state_i;
    result_o = '0;
    turn_t   = '0;
    case (item_i.func)
      FUNC_DETECT: begin
        if (!state_i.primed) begin
          state_o.fcol   = {item_i.pixel_column, 8'd0};
          state_o.fdep   = dep_sample;
          state_o.primed = 1'b1;
        end else begin
          state_o.fcol = col_acc[27:8];
          state_o.fdep = dep_acc[31:8];
        end
        if (state_i.phase != PHASE_DONE) begin
          state_o.count = (cnt_inc > cnt_cap) ? cnt_cap[8:0] : cnt_inc[8:0];
        end
        state_o.ticks     = '0;
        state_o.stop_sent = 1'b0;
      end
      FUNC_TICK: begin
        state_o.ticks = ticks_inc;
        case (state_i.mode)
          MODE_DONE: begin
            state_o.phase = PHASE_DONE;
          end
          MODE_RUN: begin
            // lost target: drop filters, one stop command, decay confidence
            if (ticks_inc > TimeoutTicks && state_i.phase != PHASE_DONE) begin
              state_o.fcol    = '0;
              state_o.fdep    = '0;
              state_o.primed  = 1'b0;
              state_o.turning = 1'b0;
              if (!state_i.stop_sent) begin
                result_o.cmd_valid = 1'b1;
                state_o.phase      = PHASE_WORKING;
                state_o.stop_sent  = 1'b1;
              end else begin
                state_o.phase = PHASE_INIT;
              end
              if (state_i.count <= 9'd1) begin
                state_o.count  = '0;
                state_o.motion = 1'b0;
              end else begin
                state_o.count = state_i.count - 9'd1;
              end
            end
            if (state_o.count > {1'b0, cfg_i.conf_thresh}) begin
              state_o.motion = 1'b1;
            end
            // steering and approach; only reachable without a timeout
            if (state_o.fcol > 20'd5120 && state_o.phase != PHASE_DONE) begin
              if (ticks_inc < LostTurnTicks) begin
                if (mag > {cfg_i.turn_start, 8'd0} && !state_i.turning) begin
                  turn_t          = turn_sat;
                  state_o.turning = 1'b1;
                end else if (state_i.turning && mag > {cfg_i.turn_stop, 8'd0}) begin
                  turn_t = turn_sat;
                end else begin
                  state_o.turning = 1'b0;
                end
              end else begin
                state_o.turning = 1'b0;
              end
              if (state_i.fdep > {1'b0, cfg_i.close_dist, 7'd0}) begin
                if (state_o.motion) begin
                  result_o.cmd_valid   = 1'b1;
                  result_o.forward_cmd = cfg_i.fwd_speed;
                  result_o.turn_cmd    = $signed(turn_t);
                  state_o.phase        = PHASE_WORKING;
                end
              end else begin
                // close enough: stop, finish on the second close tick
                if (!state_i.close_seen) begin
                  state_o.close_seen = 1'b1;
                end else begin
                  state_o.phase = PHASE_DONE;
                end
                state_o.count        = '0;
                state_o.motion       = 1'b0;
                result_o.cmd_valid   = 1'b1;
                result_o.forward_cmd = '0;
                result_o.turn_cmd    = '0;
              end
            end
          end
          default: ;
        endcase
      end
      FUNC_TRIGGER: begin
        if (item_i.trigger_value == TrigRun) begin
          state_o.mode = MODE_RUN;
        end else if (item_i.trigger_value == TrigDone) begin
          state_o.mode = MODE_DONE;
        end else begin
          state_o            = StateReset;
          state_o.ticks      = state_i.ticks;
        end
      end
      default: ;
    endcase
    result_o.control_state = state_o.phase;
  end

endmodule

@@ sim/tb_target_approach_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_target_approach_controller_core: stream-level test of the approach core
// Detections, control ticks and mode triggers are sent over s_axis. A behavioral
// copy of the controller predicts one command item per input item, and every
// m_axis item is checked field by field. Register settings change between test
// phases, and sender gaps, receiver stalls and a long hold-off are exercised.
// ----------------------------------------------------------------------------
module tb_target_approach_controller_core;
  import tac_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int HoldCycles    = 400;
  localparam logic [1:0] FuncUnused = 2'd3;

  // one input item as sent on the stream
  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] pixel_column;
    logic [15:0] depth_mm;
    logic [7:0]  trigger_value;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // pixel_column[11:0], depth_mm[27:12], trigger_value[35:28]
  logic [1:0]  s_axis_tuser = '0;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // forward_cmd[15:0], turn_cmd[31:16], control_state[33:32]
  logic        m_axis_tuser;        // cmd_valid
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  target_approach_controller_core u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Test bookkeeping
  result_t expected_cmds[$];
  int      error_count = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  // Predicted controller state and register copy
  logic [31:0] cfg_regs [8];
  logic [31:0] est_col;
  logic [31:0] est_depth;
  bit          est_primed;
  logic [31:0] est_conf;
  phase_e      est_phase;
  bit          est_turning;
  bit          est_stop_sent;
  bit          est_motion;
  bit          est_close_seen;
  mode_e       est_mode;
  logic [7:0]  est_ticks;

  task automatic log_error(input string what, input logic [39:0] exp_v, input logic [39:0] act_v);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR %s: expected %0h, got %0h at %0t", what, exp_v, act_v, $time);
    end
  endtask

  function automatic logic [31:0] reg_mask(input logic [2:0] idx);
    case (idx)
      RegGain, RegFwd, RegClose: return 32'hFFFF;
      RegWeight:                 return 32'h1FF;
      RegConf:                   return 32'hFF;
      default:                   return 32'hFFF;
    endcase
  endfunction

  function automatic logic [31:0] lowpass(input logic [31:0] prev, input logic [31:0] sample,
                                          input logic [31:0] w);
    longint acc;
    acc = longint'(sample) * longint'(w) + longint'(prev) * (256 - longint'(w)) + 128;
    return 32'(acc >> 8);
  endfunction

  // error * gain in Q3.12, rounded half away from zero, saturated
  function automatic logic [15:0] turn_rate(input longint err);
    longint mag, r;
    mag = (err < 0) ? -err : err;
    r = (mag * longint'(cfg_regs[RegGain]) + 2048) >>> 12;
    if (err < 0) return (r > 32768) ? 16'h8000 : 16'(-r);
    return (r > 32767) ? 16'h7FFF : 16'(r);
  endfunction

  task automatic clear_tracking();
    est_col = '0;
    est_depth = '0;
    est_primed = 1'b0;
    est_turning = 1'b0;
  endtask

  task automatic clear_control();
    clear_tracking();
    est_phase = PHASE_INIT;
    est_stop_sent = 1'b0;
    est_motion = 1'b0;
    est_close_seen = 1'b0;
    est_conf = '0;
  endtask

  // Work out the command item that one input item produces
  task automatic predict_command(input stim_t it, output result_t res);
    logic [31:0] w, d, cap;
    longint      err, mag;
    logic [15:0] t, fwd, trn;
    bit          valid;
    valid = 1'b0;
    fwd = '0;
    trn = '0;
    t = '0;
    case (it.func)
      FUNC_DETECT: begin
        w = (cfg_regs[RegWeight] > 256) ? 32'd256 : cfg_regs[RegWeight];
        d = 32'(it.depth_mm);
        if (d < 100) d = cfg_regs[RegClose] + 500;
        else if (d > 10000) d = 10000;
        if (!est_primed) begin
          est_col = 32'(it.pixel_column) << 8;
          est_depth = d << 7;
          est_primed = 1'b1;
        end else begin
          est_col = lowpass(est_col, 32'(it.pixel_column) << 8, w);
          est_depth = lowpass(est_depth, d << 7, w);
        end
        if (est_phase != PHASE_DONE) begin
          cap = cfg_regs[RegConf] + 2;
          est_conf++;
          if (est_conf > cap) est_conf = cap;
        end
        est_ticks = '0;
        est_stop_sent = 1'b0;
      end
      FUNC_TICK: begin
        if (est_ticks < 8'd255) est_ticks++;
        if (est_mode == MODE_DONE) begin
          est_phase = PHASE_DONE;
        end else if (est_mode == MODE_RUN) begin
          // target lost: drop the filters, send one stop, decay confidence
          if (est_ticks > TimeoutTicks && est_phase != PHASE_DONE) begin
            clear_tracking();
            if (!est_stop_sent) begin
              valid = 1'b1;
              est_phase = PHASE_WORKING;
              est_stop_sent = 1'b1;
            end else begin
              est_phase = PHASE_INIT;
            end
            if (est_conf <= 1) begin
              est_conf = '0;
              est_motion = 1'b0;
            end else begin
              est_conf--;
            end
          end
          if (est_conf > cfg_regs[RegConf]) est_motion = 1'b1;
          if (est_col > 32'd5120 && est_phase != PHASE_DONE) begin
            err = longint'(cfg_regs[RegTarget]) * 256 - longint'(est_col);
            mag = (err < 0) ? -err : err;
            // turn hysteresis, only while detections are recent
            if (est_ticks < LostTurnTicks) begin
              if (mag > longint'(cfg_regs[RegStart]) * 256 && !est_turning) begin
                t = turn_rate(err);
                est_turning = 1'b1;
              end else if (est_turning && mag > longint'(cfg_regs[RegStop]) * 256) begin
                t = turn_rate(err);
              end else begin
                est_turning = 1'b0;
              end
            end else begin
              est_turning = 1'b0;
            end
            if (longint'(est_depth) > longint'(cfg_regs[RegClose]) * 128) begin
              if (est_motion) begin
                valid = 1'b1;
                fwd = cfg_regs[RegFwd][15:0];
                trn = t;
                est_phase = PHASE_WORKING;
              end
            end else begin
              // close: stop, and complete on the second close tick
              if (!est_close_seen) est_close_seen = 1'b1;
              else est_phase = PHASE_DONE;
              est_conf = '0;
              valid = 1'b1;
              est_motion = 1'b0;
            end
          end
        end
      end
      FUNC_TRIGGER: begin
        if (it.trigger_value == TrigRun) begin
          est_mode = MODE_RUN;
        end else if (it.trigger_value == TrigDone) begin
          est_mode = MODE_DONE;
        end else begin
          est_mode = MODE_IDLE;
          clear_control();
        end
      end
      default: ;
    endcase
    res.cmd_valid = valid;
    res.forward_cmd = valid ? fwd : 16'd0;
    res.turn_cmd = valid ? trn : 16'd0;
    res.control_state = est_phase;
  endtask

  // Item builders: unused fields carry random bits
  function automatic stim_t any_item();
    stim_t it;
    it = stim_t'({$urandom, $urandom});
    return it;
  endfunction

  function automatic stim_t detect_item(input int col, input int depth);
    stim_t it;
    it = any_item();
    it.func = FUNC_DETECT;
    it.pixel_column = 12'(col);
    it.depth_mm = 16'(depth);
    return it;
  endfunction

  function automatic stim_t tick_item();
    stim_t it;
    it = any_item();
    it.func = FUNC_TICK;
    return it;
  endfunction

  function automatic stim_t trigger_item(input logic [7:0] value);
    stim_t it;
    it = any_item();
    it.func = FUNC_TRIGGER;
    it.trigger_value = value;
    return it;
  endfunction

  // Send one item; the expectation is formed at the accepting edge
  task automatic send_item(input stim_t it);
    result_t res;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, it.trigger_value, it.depth_mm, it.pixel_column};
    s_axis_tuser <= it.func;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_command(it, res);
    expected_cmds.push_back(res);
    items_sent++;
  endtask

  // Stop sending and wait until every command item has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_transfer(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a register with junk above its width, then read it back
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask, rd;
    mask = reg_mask(idx);
    apb_transfer(1'b1, idx, ($urandom & ~mask) | (value & mask), rd);
    cfg_regs[idx] = value & mask;
    apb_transfer(1'b0, idx, $urandom, rd);
    if (rd !== cfg_regs[idx])
      log_error($sformatf("register %0d readback", idx), 40'(cfg_regs[idx]), 40'(rd));
  endtask

  task automatic apply_settings(input int start, input int stop, input int gain, input int weight,
                                input int fwd, input int target, input int close_d, input int conf);
    drain();
    write_reg(RegStart, start);
    write_reg(RegStop, stop);
    write_reg(RegGain, gain);
    write_reg(RegWeight, weight);
    write_reg(RegFwd, fwd);
    write_reg(RegTarget, target);
    write_reg(RegClose, close_d);
    write_reg(RegConf, conf);
  endtask

  task automatic random_settings();
    int start;
    start = $urandom_range(0, 300);
    apply_settings(start, $urandom_range(0, start), $urandom_range(0, 65535),
                   $urandom_range(1, 256), $urandom_range(0, 65535), $urandom_range(0, 4095),
                   $urandom_range(200, 6000), $urandom_range(0, 8));
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // A run toward the target: detections closing in, with ticks between them
  task automatic send_approach();
    int steps, base_d, step_d, spread, col, depth;
    if ($urandom_range(0, 3) != 0) send_item(trigger_item(TrigRun));
    steps = $urandom_range(3, 14);
    base_d = int'(cfg_regs[RegClose]) + int'($urandom_range(200, 4000));
    step_d = $urandom_range(50, 700);
    case ($urandom_range(0, 2))
      0: spread = 20;
      1: spread = 80;
      default: spread = 1500;
    endcase
    for (int i = 0; i < steps; i++) begin
      col = int'(cfg_regs[RegTarget]) + int'($urandom_range(0, 2 * spread)) - spread;
      if (col < 0) col = 0;
      if (col > 4095) col = 4095;
      case ($urandom_range(0, 19))
        0: depth = $urandom_range(0, 99);
        1: depth = $urandom_range(10001, 65535);
        default: begin
          depth = base_d - i * step_d;
          if (depth < 100) depth = 100 + $urandom_range(0, 50);
          if (depth > 65535) depth = 65535;
        end
      endcase
      send_item(detect_item(col, depth));
      repeat ($urandom_range(0, 3)) send_item(tick_item());
    end
    // long silence: lost-turn window and timeout
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(8, 30)) send_item(tick_item());
  endtask

  task automatic run_random_traffic(input int count);
    int goal, r;
    goal = items_sent + count;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_approach();
      end else if (r < 85) begin
        case ($urandom_range(0, 3))
          0: send_item(trigger_item(TrigDone));
          1: send_item(trigger_item(TrigRun));
          2: send_item(trigger_item(8'($urandom_range(0, 255))));
          default: send_item(trigger_item(8'd0));
        endcase
      end else begin
        send_item(any_item());
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    stim_t it;
    set_idling(0, 0);
    send_item(tick_item());                 // tick in idle mode
    it = '1;                                // unused item kind, all fields high
    send_item(it);
    send_item(trigger_item(8'd255));
    send_item(trigger_item(TrigRun));
    send_item(detect_item(0, 0));           // first sample loads, near depth replaced
    send_item(detect_item(4095, 65535));    // far depth clamped
    send_item(detect_item(424, 99));
    send_item(detect_item(424, 100));
    send_item(detect_item(1000, 10000));
    send_item(detect_item(1000, 10001));
    send_item(tick_item());
    send_item(tick_item());
    send_item(detect_item(430, 3000));
    send_item(tick_item());
    send_item(detect_item(424, 150));
    send_item(tick_item());
    send_item(tick_item());
    send_item(tick_item());
    send_item(trigger_item(TrigDone));
    send_item(tick_item());
    send_item(detect_item(600, 5000));      // no confidence gain once done
    send_item(trigger_item(8'd0));
    send_item(trigger_item(8'd3));
    send_item(tick_item());
    send_item(trigger_item(TrigRun));
  endtask

  task automatic test_default_traffic();
    apply_settings(30, 15, 66, 51, 256, 424, 2000, 3);
    set_idling(0, 0);
    run_random_traffic(250);
  endtask

  task automatic test_random_settings();
    random_settings();
    set_idling(59, 0);
    run_random_traffic(250);
  endtask

  task automatic test_low_extremes();
    apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
    set_idling(0, 59);
    run_random_traffic(200);
  endtask

  task automatic test_high_extremes();
    apply_settings(4095, 4095, 65535, 256, 65535, 4095, 65535, 255);
    set_idling(27, 27);
    run_random_traffic(200);
  endtask

  // weight beyond full scale acts as full scale; maximum gain saturates turns
  task automatic test_large_weight();
    apply_settings(5, 2, 65535, 511, 1234, 4095, 300, 1);
    set_idling(0, 0);
    run_random_traffic(120);
    apply_settings(40, 10, 65535, 300, 65535, 0, 1500, 2);
    set_idling(27, 27);
    run_random_traffic(120);
  endtask

  task automatic test_backpressure();
    drain();
    set_idling(0, 0);
    hold_req = 1'b1;
    run_random_traffic(80);
  endtask

  task automatic test_mixed_random();
    for (int p = 0; p < 3; p++) begin
      random_settings();
      case (p)
        0: set_idling(0, 59);
        1: set_idling(27, 27);
        default: set_idling(59, 0);
      endcase
      run_random_traffic(130);
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_cmds.size() == 0) begin
        log_error($sformatf("result %0d without pending item", results_seen), '0, m_axis_tdata);
      end else begin
        want = expected_cmds.pop_front();
        if (m_axis_tuser !== want.cmd_valid)
          log_error($sformatf("result %0d cmd_valid", results_seen), 40'(want.cmd_valid),
                    40'(m_axis_tuser));
        if (m_axis_tdata[15:0] !== want.forward_cmd)
          log_error($sformatf("result %0d forward_cmd", results_seen), 40'(want.forward_cmd),
                    40'(m_axis_tdata[15:0]));
        if (m_axis_tdata[31:16] !== want.turn_cmd)
          log_error($sformatf("result %0d turn_cmd", results_seen), {24'd0, want.turn_cmd},
                    40'(m_axis_tdata[31:16]));
        if (m_axis_tdata[33:32] !== want.control_state)
          log_error($sformatf("result %0d control_state", results_seen),
                    40'(want.control_state), 40'(m_axis_tdata[33:32]));
        if (m_axis_tdata[39:34] !== 6'd0)
          log_error($sformatf("result %0d padding", results_seen), '0,
                    40'(m_axis_tdata[39:34]));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: cycles with no handshake on any port
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TIMEOUT after %0d idle cycles at %0t", quiet_cycles, $time);
      $display("target_approach_controller_core: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) cfg_regs[i] = '0;
    cfg_regs[RegStart]  = 32'(CfgReset.turn_start);
    cfg_regs[RegStop]   = 32'(CfgReset.turn_stop);
    cfg_regs[RegGain]   = 32'(CfgReset.turn_gain);
    cfg_regs[RegWeight] = 32'(CfgReset.weight);
    cfg_regs[RegFwd]    = 32'(CfgReset.fwd_speed);
    cfg_regs[RegTarget] = 32'(CfgReset.target_col);
    cfg_regs[RegClose]  = 32'(CfgReset.close_dist);
    cfg_regs[RegConf]   = 32'(CfgReset.conf_thresh);
    clear_control();
    est_mode = MODE_IDLE;
    est_ticks = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_default_traffic();
    test_random_settings();
    test_low_extremes();
    test_high_extremes();
    test_large_weight();
    test_backpressure();
    test_mixed_random();

    drain();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("target_approach_controller_core: match");
    end else begin
      $display("target_approach_controller_core: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tac_pkg.sv
rtl/tac_step.sv
rtl/target_approach_controller_core.sv
sim/tb_target_approach_controller_core.sv
